FILE: hw/rtl/context_bitplane_decompressor_macros.svh
// ---------------------------------------------------------------------------
// Context bitplane decompressor assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef CONTEXT_BITPLANE_DECOMPRESSOR_MACROS_SVH
`define CONTEXT_BITPLANE_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbd assertion failed");

// Next-cycle implication, disabled in reset
`define CBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbd assertion failed");

`endif

FILE: hw/rtl/cbd_pkg.sv
// ---------------------------------------------------------------------------
// cbd_pkg
// Types, constants and tables of the context bitplane decompressor.
// ---------------------------------------------------------------------------
package cbd_pkg;

    localparam int RING_DEPTH = 32;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int RING_FW    = $clog2(RING_DEPTH + 1);

    // Input word kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_PULL  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_STARVED = 2'd1;
    localparam logic [1:0] STAT_IDLE    = 2'd2;

    localparam logic [1:0] PMODE_BYTE = 2'd3;

    typedef enum logic [1:0] {
        OP_START,
        OP_PUSH,
        OP_PULL
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] len;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLANE,
        ST_GEN,
        ST_OUT
    } eng_state_t;

    typedef struct packed {
        logic [2:0] code;
        logic [5:0] nxt_mps;
        logic [5:0] nxt_lps;
    } evo_t;

    // Probability state evolution: Golomb order, next on run end, next on LPS
    function automatic evo_t evo_entry(input logic [5:0] st);
        evo_t e;
        case (st)
            6'd0:  e = '{3'd0, 6'd25, 6'd25};
            6'd1:  e = '{3'd0, 6'd2,  6'd1};
            6'd2:  e = '{3'd0, 6'd3,  6'd1};
            6'd3:  e = '{3'd0, 6'd4,  6'd2};
            6'd4:  e = '{3'd0, 6'd5,  6'd3};
            6'd5:  e = '{3'd1, 6'd6,  6'd4};
            6'd6:  e = '{3'd1, 6'd7,  6'd5};
            6'd7:  e = '{3'd1, 6'd8,  6'd6};
            6'd8:  e = '{3'd1, 6'd9,  6'd7};
            6'd9:  e = '{3'd2, 6'd10, 6'd8};
            6'd10: e = '{3'd2, 6'd11, 6'd9};
            6'd11: e = '{3'd2, 6'd12, 6'd10};
            6'd12: e = '{3'd2, 6'd13, 6'd11};
            6'd13: e = '{3'd3, 6'd14, 6'd12};
            6'd14: e = '{3'd3, 6'd15, 6'd13};
            6'd15: e = '{3'd3, 6'd16, 6'd14};
            6'd16: e = '{3'd3, 6'd17, 6'd15};
            6'd17: e = '{3'd4, 6'd18, 6'd16};
            6'd18: e = '{3'd4, 6'd19, 6'd17};
            6'd19: e = '{3'd5, 6'd20, 6'd18};
            6'd20: e = '{3'd5, 6'd21, 6'd19};
            6'd21: e = '{3'd6, 6'd22, 6'd20};
            6'd22: e = '{3'd6, 6'd23, 6'd21};
            6'd23: e = '{3'd7, 6'd24, 6'd22};
            6'd24: e = '{3'd7, 6'd24, 6'd23};
            6'd25: e = '{3'd0, 6'd26, 6'd1};
            6'd26: e = '{3'd1, 6'd27, 6'd2};
            6'd27: e = '{3'd2, 6'd28, 6'd4};
            6'd28: e = '{3'd3, 6'd29, 6'd8};
            6'd29: e = '{3'd4, 6'd30, 6'd12};
            6'd30: e = '{3'd5, 6'd31, 6'd16};
            6'd31: e = '{3'd6, 6'd32, 6'd18};
            6'd32: e = '{3'd7, 6'd24, 6'd22};
            default: e = '{3'd0, 6'd25, 6'd25};
        endcase
        return e;
    endfunction

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/cbd_front.sv
// ---------------------------------------------------------------------------
// cbd_front
// Accepts input words, turns them into engine commands, and buffers them
// in a two-entry queue. Words of unused kind are dropped here.
// ---------------------------------------------------------------------------
module cbd_front
    import cbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_out_length,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       keep;
    logic       push;
    cmd_t       cls;

    // Classify
    always_comb begin
        cls      = '{OP_PULL, s_data_byte, s_out_length};
        keep     = 1'b1;
        case (s_kind)
            KIND_START: cls.op = OP_START;
            KIND_PUSH:  cls.op = OP_PUSH;
            KIND_PULL:  cls.op = OP_PULL;
            default:    keep = 1'b0;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

FILE: hw/rtl/cbd_engine.sv
// ---------------------------------------------------------------------------
// cbd_engine
// Runs commands: start clears the model, push fills the compressed ring,
// pull returns one output byte, decoded bit by bit through the context model.
// ---------------------------------------------------------------------------
module cbd_engine
    import cbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic [1:0] m_status
);

`include "context_bitplane_decompressor_macros.svh"

    eng_state_t state_reg, state_next;

    logic [7:0]         ring [RING_DEPTH];
    logic [7:0]         rd0_reg, rd1_reg;
    logic [RING_AW-1:0] head_reg, head_inc;
    logic [RING_FW-1:0] fill_reg;
    logic [2:0]         off_reg;
    logic [1:0]         pmode_reg, cmode_reg;
    logic [2:0]         plane_reg;
    logic [6:0]         bitcnt_reg;
    logic [15:0]        hist_reg [8];
    logic [5:0]         cst_reg [32];
    logic               mps_reg [32];
    logic [7:0]         run_reg [8];
    logic               lps_reg [8];
    logic [7:0]         held_reg;
    logic               heldv_reg, helds_reg;
    logic [16:0]        left_reg;
    logic               starved_reg;
    logic [4:0]         ctx_reg;
    logic [3:0]         step_reg;
    logic [7:0]         res_reg, sec_reg;
    logic               noxfer_reg, pair_reg;
    logic               m_valid_reg, m_last_reg;
    logic [7:0]         m_byte_reg;
    logic [1:0]         m_stat_reg;

    // Control decode
    logic do_start, do_push, do_pull, out_fire, last_bit, take_held;

    // Ring addressing
    logic [RING_AW:0]   tail_sum;
    logic [RING_AW-1:0] tail;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;

    assign head_inc = (head_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_reg} + (RING_AW + 1)'(fill_reg);
    assign tail     = (tail_sum >= (RING_AW + 1)'(RING_DEPTH))
                      ? RING_AW'(tail_sum - (RING_AW + 1)'(RING_DEPTH))
                      : tail_sum[RING_AW-1:0];

    // Compressed byte ring, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= cmd.data;
        end
        rd0_reg <= ring[head_reg];
        rd1_reg <= ring[head_inc];
    end

    // Plane selection and context formation
    logic [2:0]  pl_new;
    logic [15:0] h;
    logic [4:0]  ctx_new;
    always_comb begin
        pl_new = plane_reg ^ 3'd1;
        unique case (pmode_reg)
            2'd0: pl_new = plane_reg ^ 3'd1;
            2'd1: if (bitcnt_reg == 7'd0) pl_new = (plane_reg ^ 3'd1) + 3'd2;
            2'd2: if (bitcnt_reg == 7'd0) pl_new = plane_reg ^ 3'd3;
            default: pl_new = bitcnt_reg[2:0];
        endcase
        h = hist_reg[pl_new];
        unique case (cmode_reg)
            2'd0:    ctx_new = {pl_new[0], h[8:6], h[0]};
            2'd1:    ctx_new = {pl_new[0], h[8:7], 1'b0, h[0]};
            2'd2:    ctx_new = {pl_new[0], 1'b0, h[7:6], h[0]};
            default: ctx_new = {pl_new[0], h[8:7], h[1:0]};
        endcase
    end

    // Run generator with codeword fetch
    logic [5:0] st, st_eff;
    evo_t       ent;
    logic [2:0] k;
    logic [7:0] rl, rl1, rl2, mask, b0, b1, cw0, cw, bits, rev, run_f;
    logic       lp, lp1, lp2, fetch, bit_raw, run_end, out_bit, stv;
    logic [3:0] cnt, cnt2;
    logic       adv;
    always_comb begin
        st      = cst_reg[ctx_reg];
        st_eff  = (st > 6'd32) ? 6'd0 : st;
        ent     = evo_entry(st_eff);
        k       = ent.code;
        rl      = run_reg[k];
        lp      = lps_reg[k];
        fetch   = (rl == 8'd0) && !lp;
        mask    = 8'((9'd1 << k) - 9'd1);
        b0      = (fill_reg != '0) ? rd0_reg : 8'd0;
        cw0     = 8'({8'h00, b0} << off_reg);
        cnt     = {1'b0, off_reg} + 4'd1;
        stv     = fetch && (fill_reg == '0);
        cw      = cw0;
        cnt2    = cnt;
        b1      = (fill_reg > RING_FW'(1)) ? rd1_reg : 8'd0;
        if (cw0[7]) begin
            cw   = cw0 | (b1 >> (4'd9 - cnt));
            cnt2 = cnt + {1'b0, k};
            stv  = stv || (fetch && (fill_reg <= RING_FW'(1)));
        end
        adv     = fetch && cnt2[3];
        bits    = (cw >> (3'd7 - k)) & mask;
        rev     = 8'(bit_rev8(bits) >> (4'd8 - {1'b0, k}));
        run_f   = cw[7] ? (rev ^ mask) : 8'(9'd1 << k);
        rl1     = fetch ? run_f : rl;
        lp1     = fetch ? cw[7] : lp;
        bit_raw = (rl1 == 8'd0);
        rl2     = bit_raw ? rl1 : rl1 - 8'd1;
        lp2     = bit_raw ? 1'b0 : lp1;
        run_end = (rl2 == 8'd0) && !lp2;
        out_bit = bit_raw ^ mps_reg[ctx_reg];
    end

    // FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign last_bit = (pmode_reg == PMODE_BYTE) ? (step_reg == 4'd7) : (step_reg == 4'd15);
    assign out_fire = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        do_start   = 1'b0;
        do_push    = 1'b0;
        do_pull    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_START: do_start = 1'b1;
                        OP_PUSH:  do_push  = 1'b1;
                        default: begin
                            do_pull = 1'b1;
                            if (left_reg == 17'd0 ||
                                (pmode_reg != PMODE_BYTE && heldv_reg)) begin
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_PLANE;
                            end
                        end
                    endcase
                end
            end
            ST_PLANE: state_next = ST_GEN;
            ST_GEN:   state_next = last_bit ? ST_OUT : ST_PLANE;
            default:  if (out_fire) state_next = ST_IDLE;
        endcase
    end

    assign wr_en     = do_start || (do_push && fill_reg < RING_FW'(RING_DEPTH));
    assign wr_addr   = do_start ? '0 : tail;
    assign take_held = (left_reg != 17'd0) && (pmode_reg != PMODE_BYTE) && heldv_reg;

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= '0;
            off_reg     <= 3'd4;
            pmode_reg   <= 2'd0;
            cmode_reg   <= 2'd0;
            plane_reg   <= 3'd0;
            bitcnt_reg  <= 7'd0;
            held_reg    <= 8'd0;
            heldv_reg   <= 1'b0;
            helds_reg   <= 1'b0;
            left_reg    <= 17'd0;
            starved_reg <= 1'b0;
            noxfer_reg  <= 1'b0;
            pair_reg    <= 1'b0;
            step_reg    <= 4'd0;
            for (int i = 0; i < 8; i++) begin
                hist_reg[i] <= 16'd0;
                run_reg[i]  <= 8'd0;
                lps_reg[i]  <= 1'b0;
            end
            for (int i = 0; i < 32; i++) begin
                cst_reg[i] <= 6'd0;
                mps_reg[i] <= 1'b0;
            end
        end else begin
            if (do_start) begin
                head_reg   <= '0;
                fill_reg   <= RING_FW'(1);
                off_reg    <= 3'd4;
                pmode_reg  <= cmd.data[7:6];
                cmode_reg  <= cmd.data[5:4];
                unique case (cmd.data[7:6])
                    2'd0:    plane_reg <= 3'd1;
                    2'd1:    plane_reg <= 3'd7;
                    2'd2:    plane_reg <= 3'd3;
                    default: plane_reg <= 3'd0;
                endcase
                bitcnt_reg <= 7'd0;
                held_reg   <= 8'd0;
                heldv_reg  <= 1'b0;
                helds_reg  <= 1'b0;
                left_reg   <= (cmd.len == 16'd0) ? 17'h10000 : {1'b0, cmd.len};
                for (int i = 0; i < 8; i++) begin
                    hist_reg[i] <= 16'd0;
                    run_reg[i]  <= 8'd0;
                    lps_reg[i]  <= 1'b0;
                end
                for (int i = 0; i < 32; i++) begin
                    cst_reg[i] <= 6'd0;
                    mps_reg[i] <= 1'b0;
                end
            end
            if (do_push && fill_reg < RING_FW'(RING_DEPTH)) begin
                fill_reg <= fill_reg + 1'b1;
            end
            // Pull setup
            if (do_pull) begin
                step_reg    <= 4'd0;
                noxfer_reg  <= (left_reg == 17'd0);
                pair_reg    <= (pmode_reg != PMODE_BYTE) && !heldv_reg;
                starved_reg <= take_held ? helds_reg : 1'b0;
                if (take_held) begin
                    res_reg   <= held_reg;
                    heldv_reg <= 1'b0;
                end
            end
            if (state_reg == ST_PLANE) begin
                plane_reg <= pl_new;
                ctx_reg   <= ctx_new;
            end
            // One context bit
            if (state_reg == ST_GEN) begin
                run_reg[k] <= rl2;
                lps_reg[k] <= lp2;
                if (adv) begin
                    head_reg <= head_inc;
                    if (fill_reg != '0) fill_reg <= fill_reg - 1'b1;
                end
                if (fetch) off_reg <= cnt2[2:0];
                starved_reg <= starved_reg || stv;
                if (run_end) begin
                    if (bit_raw) begin
                        if (st_eff < 6'd2) mps_reg[ctx_reg] <= !mps_reg[ctx_reg];
                        cst_reg[ctx_reg] <= ent.nxt_lps;
                    end else begin
                        cst_reg[ctx_reg] <= ent.nxt_mps;
                    end
                end
                hist_reg[plane_reg] <= {hist_reg[plane_reg][14:0], out_bit};
                bitcnt_reg <= bitcnt_reg + 7'd1;
                step_reg   <= step_reg + 4'd1;
                if (pmode_reg == PMODE_BYTE) begin
                    res_reg <= {out_bit, res_reg[7:1]};
                end else if (!step_reg[0]) begin
                    res_reg <= {res_reg[6:0], out_bit};
                end else begin
                    sec_reg <= {sec_reg[6:0], out_bit};
                end
            end
            // Result handoff
            if (state_reg == ST_OUT && out_fire && !noxfer_reg) begin
                left_reg <= left_reg - 17'd1;
                if (left_reg == 17'd1) begin
                    heldv_reg <= 1'b0;
                    helds_reg <= 1'b0;
                end else if (pair_reg) begin
                    held_reg  <= sec_reg;
                    heldv_reg <= 1'b1;
                    helds_reg <= starved_reg;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_fire) begin
            m_valid_reg <= 1'b1;
            m_byte_reg  <= noxfer_reg ? 8'd0 : res_reg;
            m_last_reg  <= !noxfer_reg && (left_reg == 17'd1);
            m_stat_reg  <= noxfer_reg ? STAT_IDLE : (starved_reg ? STAT_STARVED : STAT_OK);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;
    assign m_status   = m_stat_reg;

    `CBD_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= RING_FW'(RING_DEPTH))
    `CBD_ASSERT_IMPL(a_held_mode, aclk, aresetn, heldv_reg, pmode_reg != PMODE_BYTE)
    `CBD_ASSERT_IMPL(a_held_xfer, aclk, aresetn, heldv_reg, left_reg != 17'd0)
    `CBD_ASSERT_IMPL(a_pop_idle, aclk, aresetn, cmd_pop, state_reg == ST_IDLE && cmd_valid)

endmodule

FILE: hw/rtl/context_bitplane_decompressor.sv
// ---------------------------------------------------------------------------
// context_bitplane_decompressor
// Context-modelled Golomb run-length bitplane decompressor, top level.
//
//  channel | dir | ports                                   | moves on
//  s_      | in  | s_kind, s_data_byte, s_out_length       | s_valid & s_ready
//  m_      | out | m_out_byte, m_last, m_status            | m_valid & m_ready
//
// Start and push are done in the dispatch state. A pull that decodes goes
// through dispatch, then plane select and run generator for each context bit
// (8 in the byte-per-row mode, 16 for a pair), then handoff; a held byte or a
// pull with no transfer goes from dispatch straight to handoff.
// Reset is synchronous, active low, and clears model and control state at once.
// A two-word command queue lets input words be taken while the engine
// works or the result register waits on m_ready.
// ---------------------------------------------------------------------------
module context_bitplane_decompressor
    import cbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_out_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic [1:0]  m_status
);

    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    cbd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_data_byte  (s_data_byte),
        .s_out_length (s_out_length),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    cbd_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_status   (m_status)
    );

endmodule
